// ----- sv/pcc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pcc_pkg - pileup consensus call shared definitions
// Payload structs, base and class codes, register indexes and reset values.
// ============================================================================
package pcc_pkg;

    localparam int FIELD_BITS          = 16;
    localparam int CFG_BITS            = 16;
    localparam int CFG_IDX_BITS        = 2;
    localparam int NUM_SYMS            = 6;
    localparam int BASE_BITS           = 3;
    localparam int CLASS_BITS          = 2;
    localparam int DEF_COUNT_BITS      = 16;
    localparam int DEF_RATIO_FRAC_BITS = 8;

    // base codes
    localparam logic [BASE_BITS-1:0] BASE_A   = 3'd0;
    localparam logic [BASE_BITS-1:0] BASE_C   = 3'd1;
    localparam logic [BASE_BITS-1:0] BASE_G   = 3'd2;
    localparam logic [BASE_BITS-1:0] BASE_T   = 3'd3;
    localparam logic [BASE_BITS-1:0] BASE_DEL = 3'd4;
    localparam logic [BASE_BITS-1:0] BASE_INS = 3'd5;

    // call classes
    localparam logic [CLASS_BITS-1:0] CLASS_UNTRUSTED = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_HAPLOID   = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_DIPLOID   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_COVERAGE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_FRACTION    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEXT_MARGIN     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DISCREPANCY = 2'd3;

    localparam logic [CFG_BITS-1:0] RST_MIN_COVERAGE    = 16'd20;
    localparam logic [CFG_BITS-1:0] RST_MIN_FRACTION    = 16'd218;
    localparam logic [CFG_BITS-1:0] RST_NEXT_MARGIN     = 16'd512;
    localparam logic [CFG_BITS-1:0] RST_MAX_DISCREPANCY = 16'd166;

    // tie rank per base code (character order A C D G I T), higher wins
    localparam logic [2:0] TIE_RANK [NUM_SYMS] = '{3'd0, 3'd1, 3'd3, 3'd5, 3'd2, 3'd4};

    typedef struct packed {
        logic [FIELD_BITS-1:0] count_a;
        logic [FIELD_BITS-1:0] count_c;
        logic [FIELD_BITS-1:0] count_g;
        logic [FIELD_BITS-1:0] count_t;
        logic [FIELD_BITS-1:0] count_del;
        logic [FIELD_BITS-1:0] count_ins;
    } t_req;

    typedef struct packed {
        logic [CLASS_BITS-1:0] call_class;
        logic [BASE_BITS-1:0]  first_base;
        logic [BASE_BITS-1:0]  second_base;
    } t_rsp;

endpackage

// ----- sv/pileup_consensus_call.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pileup_consensus_call - per-position haploid / diploid consensus classifier
// Ranks six pileup counts and calls the position from the top counts.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready, payload i_req) carries one request per
//   pileup position: six counts A, C, G, T, deletion, insertion. Output
//   channel (o_valid / i_ready, payload o_rsp) returns one call per request,
//   in order.
//   Config port: i_cfg_we with i_cfg_idx / i_cfg_data writes a threshold in
//   the same cycle. Write only while the pipe is empty.
//   Pipe: four stages, one request per cycle sustained while i_ready is high.
//     s1  mask counts, pairwise key compares, total
//     s2  rank by win count, select top three counts and top two bases
//     s3  threshold multiplies (four; both fraction tests share one)
//     s4  compares, class decision; this is the output register
//   Each stage loads when it is empty or the stage after it moves, so a
//   stalled receiver fills the pipe up and o_ready drops only once all four
//   stages hold requests; bubbles are squeezed out, nothing is dropped.
//   Reset clears stage valids and loads the default thresholds.
// ============================================================================
module pileup_consensus_call #(
    parameter int COUNT_BITS      = pcc_pkg::DEF_COUNT_BITS,
    parameter int RATIO_FRAC_BITS = pcc_pkg::DEF_RATIO_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [pcc_pkg::CFG_BITS-1:0]    i_cfg_data,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  pcc_pkg::t_req                   i_req,
    // response channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output pcc_pkg::t_rsp                   o_rsp
);
    import pcc_pkg::*;

    // count width after masking; ports are fixed at FIELD_BITS
    localparam int CW = (COUNT_BITS < FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
    localparam int TW = CW + 3;           // sum of six counts
    localparam int PW = TW + CFG_BITS;    // product width; covers count << frac

    // ------------------------------------------------------------------
    // threshold registers
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0] r_min_coverage;
    logic [CFG_BITS-1:0] r_min_fraction;
    logic [CFG_BITS-1:0] r_next_margin;
    logic [CFG_BITS-1:0] r_max_discrepancy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_coverage    <= RST_MIN_COVERAGE;
            r_min_fraction    <= RST_MIN_FRACTION;
            r_next_margin     <= RST_NEXT_MARGIN;
            r_max_discrepancy <= RST_MAX_DISCREPANCY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_COVERAGE:    r_min_coverage    <= i_cfg_data;
                CFG_MIN_FRACTION:    r_min_fraction    <= i_cfg_data;
                CFG_NEXT_MARGIN:     r_next_margin     <= i_cfg_data;
                CFG_MAX_DISCREPANCY: r_max_discrepancy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valids and ready chain
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic w_s1_rdy, w_s2_rdy, w_s3_rdy, w_s4_rdy;

    assign w_s4_rdy = !r_s4_valid || i_ready;
    assign w_s3_rdy = !r_s3_valid || w_s4_rdy;
    assign w_s2_rdy = !r_s2_valid || w_s3_rdy;
    assign w_s1_rdy = !r_s1_valid || w_s2_rdy;
    assign o_ready  = w_s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_s1_rdy) r_s1_valid <= i_valid;
            if (w_s2_rdy) r_s2_valid <= r_s1_valid;
            if (w_s3_rdy) r_s3_valid <= r_s2_valid;
            if (w_s4_rdy) r_s4_valid <= r_s3_valid;
        end
    end

    // ------------------------------------------------------------------
    // s1: mask, pairwise compares, total
    // gt[i][j]: key i ranks above key j (count, then tie rank)
    // ------------------------------------------------------------------
    logic [CW-1:0]       w_cnt [NUM_SYMS];
    logic [NUM_SYMS-1:0] n_s1_gt [NUM_SYMS];
    logic [TW-1:0]       n_s1_total;

    logic [CW-1:0]       r_s1_cnt [NUM_SYMS];
    logic [NUM_SYMS-1:0] r_s1_gt [NUM_SYMS];
    logic [TW-1:0]       r_s1_total;

    assign w_cnt[0] = i_req.count_a[CW-1:0];
    assign w_cnt[1] = i_req.count_c[CW-1:0];
    assign w_cnt[2] = i_req.count_g[CW-1:0];
    assign w_cnt[3] = i_req.count_t[CW-1:0];
    assign w_cnt[4] = i_req.count_del[CW-1:0];
    assign w_cnt[5] = i_req.count_ins[CW-1:0];

    always_comb begin
        n_s1_total = '0;
        for (int i = 0; i < NUM_SYMS; i++) begin
            n_s1_total = n_s1_total + TW'(w_cnt[i]);
            for (int j = 0; j < NUM_SYMS; j++) begin
                if (i == j) begin
                    n_s1_gt[i][j] = 1'b0;
                end else if (TIE_RANK[i] > TIE_RANK[j]) begin
                    n_s1_gt[i][j] = (w_cnt[i] >= w_cnt[j]);
                end else begin
                    n_s1_gt[i][j] = (w_cnt[i] > w_cnt[j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_rdy) begin
            r_s1_cnt   <= w_cnt;
            r_s1_gt    <= n_s1_gt;
            r_s1_total <= n_s1_total;
        end
    end

    // ------------------------------------------------------------------
    // s2: win count gives rank; 5 wins is top, 4 second, 3 third
    // ------------------------------------------------------------------
    logic [2:0]           w_wins [NUM_SYMS];
    logic [CW-1:0]        n_s2_n0, n_s2_n1, n_s2_n2;
    logic [BASE_BITS-1:0] n_s2_b0, n_s2_b1;

    logic [CW-1:0]        r_s2_n0, r_s2_n1, r_s2_n2;
    logic [BASE_BITS-1:0] r_s2_b0, r_s2_b1;
    logic [TW-1:0]        r_s2_total;

    always_comb begin
        n_s2_n0 = '0;
        n_s2_n1 = '0;
        n_s2_n2 = '0;
        n_s2_b0 = BASE_A;
        n_s2_b1 = BASE_A;
        for (int i = 0; i < NUM_SYMS; i++) begin
            w_wins[i] = '0;
            for (int j = 0; j < NUM_SYMS; j++) begin
                w_wins[i] = w_wins[i] + 3'(r_s1_gt[i][j]);
            end
            if (w_wins[i] == 3'd5) begin
                n_s2_n0 = r_s1_cnt[i];
                n_s2_b0 = BASE_BITS'(i);
            end
            if (w_wins[i] == 3'd4) begin
                n_s2_n1 = r_s1_cnt[i];
                n_s2_b1 = BASE_BITS'(i);
            end
            if (w_wins[i] == 3'd3) begin
                n_s2_n2 = r_s1_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_rdy) begin
            r_s2_n0    <= n_s2_n0;
            r_s2_n1    <= n_s2_n1;
            r_s2_n2    <= n_s2_n2;
            r_s2_b0    <= n_s2_b0;
            r_s2_b1    <= n_s2_b1;
            r_s2_total <= r_s1_total;
        end
    end

    // ------------------------------------------------------------------
    // s3: threshold side of each cross-multiplied ratio test
    // ------------------------------------------------------------------
    logic [PW-1:0]        r_s3_frac_prod;   // min_fraction * total
    logic [PW-1:0]        r_s3_m1_prod;     // next_margin * n1
    logic [PW-1:0]        r_s3_m2_prod;     // next_margin * n2
    logic [PW-1:0]        r_s3_d_prod;      // max_discrepancy * n0
    logic [CW-1:0]        r_s3_n0, r_s3_n1;
    logic [CW:0]          r_s3_sum01;
    logic                 r_s3_n0_zero, r_s3_n1_zero, r_s3_n2_zero, r_s3_tot_zero;
    logic [BASE_BITS-1:0] r_s3_b0, r_s3_b1;

    always_ff @(posedge i_clk) begin
        if (w_s3_rdy) begin
            r_s3_frac_prod <= PW'(r_min_fraction) * PW'(r_s2_total);
            r_s3_m1_prod   <= PW'(r_next_margin) * PW'(r_s2_n1);
            r_s3_m2_prod   <= PW'(r_next_margin) * PW'(r_s2_n2);
            r_s3_d_prod    <= PW'(r_max_discrepancy) * PW'(r_s2_n0);
            r_s3_n0        <= r_s2_n0;
            r_s3_n1        <= r_s2_n1;
            r_s3_sum01     <= (CW+1)'(r_s2_n0) + (CW+1)'(r_s2_n1);
            r_s3_n0_zero   <= (r_s2_n0 == '0);
            r_s3_n1_zero   <= (r_s2_n1 == '0);
            r_s3_n2_zero   <= (r_s2_n2 == '0);
            r_s3_tot_zero  <= (r_s2_total == '0);
            r_s3_b0        <= r_s2_b0;
            r_s3_b1        <= r_s2_b1;
        end
    end

    // ------------------------------------------------------------------
    // s4: compares and class decision
    // a zero fraction or discrepancy denominator passes only at threshold 0
    // ------------------------------------------------------------------
    logic [PW-1:0] w_n0_sh, w_n1_sh, w_sum_sh;
    logic          w_hap_cov, w_hap_frac, w_hap_next, w_hap;
    logic          w_dip_cov, w_dip_frac, w_dip_next, w_dip_disc, w_dip;
    t_rsp          n_s4_rsp;
    t_rsp          r_s4_rsp;

    assign w_n0_sh  = PW'(r_s3_n0) << RATIO_FRAC_BITS;
    assign w_n1_sh  = PW'(r_s3_n1) << RATIO_FRAC_BITS;
    assign w_sum_sh = PW'(r_s3_sum01) << RATIO_FRAC_BITS;

    always_comb begin
        w_hap_cov  = PW'(r_s3_n0) >= PW'(r_min_coverage);
        w_hap_frac = r_s3_tot_zero ? (r_min_fraction == '0)
                                   : (w_n0_sh >= r_s3_frac_prod);
        w_hap_next = r_s3_n1_zero || (w_n0_sh >= r_s3_m1_prod);
        w_hap      = w_hap_cov && w_hap_frac && w_hap_next && (r_s3_b0 != BASE_DEL);

        w_dip_cov  = PW'(r_s3_sum01) >= PW'(r_min_coverage);
        w_dip_frac = r_s3_tot_zero ? (r_min_fraction == '0)
                                   : (w_sum_sh >= r_s3_frac_prod);
        w_dip_next = r_s3_n2_zero || (w_n1_sh >= r_s3_m2_prod);
        w_dip_disc = r_s3_n0_zero ? (r_max_discrepancy == '0)
                                  : (w_n1_sh >= r_s3_d_prod);
        w_dip      = w_dip_cov && w_dip_frac && w_dip_next && w_dip_disc &&
                     (r_s3_b0 != BASE_DEL) && (r_s3_b1 != BASE_DEL);

        n_s4_rsp.call_class  = CLASS_UNTRUSTED;
        n_s4_rsp.first_base  = BASE_A;
        n_s4_rsp.second_base = BASE_A;
        if (w_hap) begin
            n_s4_rsp.call_class = CLASS_HAPLOID;
            n_s4_rsp.first_base = r_s3_b0;
        end else if (w_dip) begin
            n_s4_rsp.call_class  = CLASS_DIPLOID;
            n_s4_rsp.first_base  = r_s3_b0;
            n_s4_rsp.second_base = r_s3_b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s4_rdy) begin
            r_s4_rsp <= n_s4_rsp;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_rsp   = r_s4_rsp;

endmodule

// ----- dv/tb_pileup_consensus_call.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_pileup_consensus_call - self-checking bench for the consensus classifier
// Streams pileup positions through the request channel under random source
// gaps and sink stalls and across several threshold settings. Each accepted
// request is scored by an in-bench caller model and compared, in order, with
// the call coming back on the response channel.
// ============================================================================
module tb_pileup_consensus_call;
    import pcc_pkg::*;

    localparam int COUNT_W      = DEF_COUNT_BITS;
    localparam int FRAC_W       = DEF_RATIO_FRAC_BITS;
    localparam int RAND_PER_SET = 200;
    localparam int IDLE_LIMIT   = 4000;   // cycles without any handshake
    localparam int DRAIN_CYCLES = 10;     // pipe is 4 deep, leave some slack

    typedef logic [FIELD_BITS-1:0] t_pos_counts [NUM_SYMS];

    // one outstanding call: request number, the position and its expected call
    typedef struct {
        int unsigned seq;
        t_req        pos;
        t_rsp        call;
    } t_pending_call;

    // ------------------------------------------------------------------------
    // clock, reset and DUT hookup
    // ------------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx   = CFG_MIN_COVERAGE;
    logic [CFG_BITS-1:0]     cfg_data  = '0;
    logic                    req_valid = 1'b0;
    logic                    req_ready;
    t_req                    req_data  = '0;
    logic                    rsp_valid;
    logic                    rsp_ready = 1'b0;
    t_rsp                    rsp_data;

    always #5 clk = ~clk;

    pileup_consensus_call #(
        .COUNT_BITS      (COUNT_W),
        .RATIO_FRAC_BITS (FRAC_W)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (req_valid),
        .o_ready    (req_ready),
        .i_req      (req_data),
        .o_valid    (rsp_valid),
        .i_ready    (rsp_ready),
        .o_rsp      (rsp_data)
    );

    // ------------------------------------------------------------------------
    // bench-side copy of the thresholds; only changed while the pipe is empty
    // ------------------------------------------------------------------------
    logic [CFG_BITS-1:0] min_cov    = RST_MIN_COVERAGE;
    logic [CFG_BITS-1:0] min_frac   = RST_MIN_FRACTION;
    logic [CFG_BITS-1:0] nxt_margin = RST_NEXT_MARGIN;
    logic [CFG_BITS-1:0] max_disc   = RST_MAX_DISCREPANCY;

    t_req          pos_q  [$];    // positions waiting to be sent
    t_pending_call call_q [$];    // calls expected back, oldest first

    bit          src_steady = 1'b0;   // no source gaps in this setting
    bit          snk_steady = 1'b0;   // no sink stalls in this setting
    int unsigned n_sent     = 0;
    int unsigned n_rcvd     = 0;
    int unsigned n_hap      = 0;
    int unsigned n_dip      = 0;
    int unsigned n_untr     = 0;
    int unsigned n_settings = 1;
    int unsigned err_cnt    = 0;

    // ------------------------------------------------------------------------
    // caller model
    // ------------------------------------------------------------------------
    // Tie order: at equal counts T beats I beats G beats D beats C beats A.
    function automatic int unsigned tie_rank(logic [BASE_BITS-1:0] b);
        case (b)
            BASE_A:   return 0;
            BASE_C:   return 1;
            BASE_DEL: return 2;
            BASE_G:   return 3;
            BASE_INS: return 4;
            default:  return 5;   // BASE_T
        endcase
    endfunction

    // num/den >= thr in Q8.8; a zero denominator reads as a quotient of 0
    function automatic bit ratio_ok(longint unsigned num, longint unsigned den,
                                    logic [CFG_BITS-1:0] thr);
        if (den == 0)
            return thr == 0;
        return (num << FRAC_W) >= (longint'(thr) * den);
    endfunction

    function automatic t_rsp call_position(t_req p);
        logic [FIELD_BITS-1:0] cnt  [NUM_SYMS];
        logic [BASE_BITS-1:0]  code [NUM_SYMS];
        logic [FIELD_BITS-1:0] tc;
        logic [BASE_BITS-1:0]  tb;
        longint unsigned       n0, n1, n2, total;
        t_rsp                  res;

        cnt[BASE_A]   = p.count_a;
        cnt[BASE_C]   = p.count_c;
        cnt[BASE_G]   = p.count_g;
        cnt[BASE_T]   = p.count_t;
        cnt[BASE_DEL] = p.count_del;
        cnt[BASE_INS] = p.count_ins;
        total = 0;
        for (int i = 0; i < NUM_SYMS; i++) begin
            code[i] = BASE_BITS'(i);
            total  += cnt[i];
        end
        // only the top three places matter
        for (int i = 0; i < 3; i++) begin
            for (int j = i + 1; j < NUM_SYMS; j++) begin
                if (cnt[j] > cnt[i] ||
                    (cnt[j] == cnt[i] && tie_rank(code[j]) > tie_rank(code[i]))) begin
                    tc = cnt[i];  cnt[i]  = cnt[j];  cnt[j]  = tc;
                    tb = code[i]; code[i] = code[j]; code[j] = tb;
                end
            end
        end
        n0 = cnt[0];
        n1 = cnt[1];
        n2 = cnt[2];

        res.call_class  = CLASS_UNTRUSTED;
        res.first_base  = BASE_A;
        res.second_base = BASE_A;
        if (n0 >= min_cov && ratio_ok(n0, total, min_frac) &&
            (n1 == 0 || ratio_ok(n0, n1, nxt_margin)) && code[0] != BASE_DEL) begin
            res.call_class = CLASS_HAPLOID;
            res.first_base = code[0];
        end else if (n0 + n1 >= min_cov && ratio_ok(n0 + n1, total, min_frac) &&
                     (n2 == 0 || ratio_ok(n1, n2, nxt_margin)) &&
                     ratio_ok(n1, n0, max_disc) &&
                     code[0] != BASE_DEL && code[1] != BASE_DEL) begin
            res.call_class  = CLASS_DIPLOID;
            res.first_base  = code[0];
            res.second_base = code[1];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // append one position to the send queue
    function automatic void add_pos(t_req p);
        pos_q = {pos_q, p};
    endfunction

    function automatic t_req pack_counts(t_pos_counts c);
        t_req p;
        p.count_a   = c[BASE_A];
        p.count_c   = c[BASE_C];
        p.count_g   = c[BASE_G];
        p.count_t   = c[BASE_T];
        p.count_del = c[BASE_DEL];
        p.count_ins = c[BASE_INS];
        return p;
    endfunction

    function automatic t_req one_base(logic [BASE_BITS-1:0] b, int unsigned n);
        t_pos_counts c;
        c    = '{default: '0};
        c[b] = FIELD_BITS'(n);
        return pack_counts(c);
    endfunction

    // Mostly well-formed pileups (one clear winner or a close pair over
    // light noise), plus ties, near-empty positions, raw noise and saturation.
    function automatic t_req gen_position();
        t_pos_counts c;
        int unsigned kind, top, b0, b1, v;

        kind = $urandom_range(0, 99);
        top  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 600);
        b0   = $urandom_range(0, NUM_SYMS - 1);
        b1   = (b0 + $urandom_range(1, NUM_SYMS - 1)) % NUM_SYMS;
        if (kind < 35) begin
            for (int i = 0; i < NUM_SYMS; i++)
                c[i] = FIELD_BITS'((i == b0) ? top
                                             : $urandom_range(0, top / $urandom_range(2, 12)));
        end else if (kind < 65) begin
            v = top * $urandom_range(40, 100) / 100;
            for (int i = 0; i < NUM_SYMS; i++) begin
                if (i == b0)
                    c[i] = FIELD_BITS'(top);
                else if (i == b1)
                    c[i] = FIELD_BITS'(v);
                else if ($urandom_range(0, 2) == 0)
                    c[i] = '0;
                else
                    c[i] = FIELD_BITS'($urandom_range(0, v / $urandom_range(2, 12)));
            end
        end else if (kind < 75) begin
            v = $urandom_range(0, 60);
            for (int i = 0; i < NUM_SYMS; i++)
                c[i] = FIELD_BITS'($urandom_range(0, 1) ? v : $urandom_range(0, v));
        end else if (kind < 85) begin
            for (int i = 0; i < NUM_SYMS; i++)
                c[i] = FIELD_BITS'($urandom_range(0, 3));
        end else if (kind < 95) begin
            for (int i = 0; i < NUM_SYMS; i++)
                c[i] = FIELD_BITS'($urandom_range(0, 65535));
        end else begin
            for (int i = 0; i < NUM_SYMS; i++)
                c[i] = FIELD_BITS'($urandom_range(0, 1) ? 65535 : $urandom_range(60000, 65535));
        end
        return pack_counts(c);
    endfunction

    // gap / stall length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // request driver: presents queued positions, holds each until accepted
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_blk
        int unsigned   gap_left;
        t_pending_call pc;

        if (req_valid && req_ready) begin
            pc.seq  = n_sent;
            pc.pos  = req_data;
            pc.call = call_position(req_data);
            call_q  = {call_q, pc};
            n_sent++;
            gap_left = src_steady ? 0 : pick_gap();
        end
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (req_valid && !req_ready) begin
            // request still pending, hold it
        end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
        end else if (pos_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pos_q.pop_front();
        end else begin
            req_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // response monitor: in-order check against the oldest expected call
    // ------------------------------------------------------------------------
    task automatic note_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge clk) begin : check_blk
        int unsigned   stall_left;
        t_pending_call pc;

        if (rst_n && rsp_valid && rsp_ready) begin
            n_rcvd++;
            if (call_q.size() == 0) begin
                note_mismatch($sformatf("call %0d/%0d/%0d with no request outstanding",
                              rsp_data.call_class, rsp_data.first_base,
                              rsp_data.second_base));
            end else begin
                pc = call_q.pop_front();
                case (pc.call.call_class)
                    CLASS_HAPLOID: n_hap++;
                    CLASS_DIPLOID: n_dip++;
                    default:       n_untr++;
                endcase
                if (rsp_data.call_class  !== pc.call.call_class ||
                    rsp_data.first_base  !== pc.call.first_base ||
                    rsp_data.second_base !== pc.call.second_base)
                    note_mismatch($sformatf(
                        "req %0d A%0d C%0d G%0d T%0d D%0d I%0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                        pc.seq, pc.pos.count_a, pc.pos.count_c, pc.pos.count_g,
                        pc.pos.count_t, pc.pos.count_del, pc.pos.count_ins,
                        pc.call.call_class, pc.call.first_base, pc.call.second_base,
                        rsp_data.call_class, rsp_data.first_base, rsp_data.second_base));
            end
        end
        // sink back-pressure
        if (snk_steady) begin
            stall_left = 0;
            rsp_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            rsp_ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no handshake on either channel for too long means a hang
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : watchdog_blk
        int unsigned idle_cyc;

        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d calls outstanding",
                     IDLE_LIMIT, call_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MIN_COVERAGE:    min_cov    = val;
            CFG_MIN_FRACTION:    min_frac   = val;
            CFG_NEXT_MARGIN:     nxt_margin = val;
            CFG_MAX_DISCREPANCY: max_disc   = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(int unsigned cov, int unsigned frac,
                                  int unsigned marg, int unsigned disc);
        write_reg(CFG_MIN_COVERAGE,    CFG_BITS'(cov));
        write_reg(CFG_MIN_FRACTION,    CFG_BITS'(frac));
        write_reg(CFG_NEXT_MARGIN,     CFG_BITS'(marg));
        write_reg(CFG_MAX_DISCREPANCY, CFG_BITS'(disc));
        n_settings++;
    endtask

    // source stops until every call is back; the pipe is then empty
    task automatic drain();
        while (pos_q.size() != 0 || req_valid || call_q.size() != 0)
            @(posedge clk);
    endtask

    // one threshold setting: edge positions first, then random traffic
    task automatic run_setting(int unsigned n_rand);
        t_pos_counts c;

        src_steady = ($urandom_range(0, 3) == 0);
        snk_steady = ($urandom_range(0, 3) == 0);
        c = '{default: '0};
        add_pos(pack_counts(c));
        c = '{default: '1};
        add_pos(pack_counts(c));
        for (int i = 0; i < n_rand; i++)
            add_pos(gen_position());
        drain();
    endtask

    initial begin
        t_pos_counts c;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed positions at the reset thresholds
        for (int b = 0; b < NUM_SYMS; b++)
            add_pos(one_base(BASE_BITS'(b), 100));   // deletion alone stays untrusted
        add_pos(one_base(BASE_A, 20));               // exactly min coverage
        add_pos(one_base(BASE_A, 19));               // one short
        c = '{default: '0}; c[BASE_A] = 60;  c[BASE_C] = 40;    add_pos(pack_counts(c));
        c = '{default: '0}; c[BASE_T] = 50;  c[BASE_INS] = 50;  add_pos(pack_counts(c));
        c = '{default: '0}; c[BASE_G] = 50;  c[BASE_DEL] = 50;  add_pos(pack_counts(c));
        c = '{default: '0}; c[BASE_A] = 50;  c[BASE_C] = 50;    add_pos(pack_counts(c));
        // fraction right at and just under the threshold
        c = '{default: '0}; c[BASE_A] = 218; c[BASE_C] = 38;    add_pos(pack_counts(c));
        c = '{default: '0}; c[BASE_A] = 217; c[BASE_C] = 39;    add_pos(pack_counts(c));
        // insertion winning over noise
        c = '{default: '0}; c[BASE_INS] = 300; c[BASE_A] = 5; c[BASE_C] = 3;
        add_pos(pack_counts(c));
        // deletion in second place blocks the pair call
        c = '{default: '0}; c[BASE_A] = 60;  c[BASE_DEL] = 40;  add_pos(pack_counts(c));
        // pair call with a third count, passing and failing the next-margin test
        c = '{default: '0}; c[BASE_A] = 100; c[BASE_C] = 80; c[BASE_G] = 10;
        add_pos(pack_counts(c));
        c[BASE_G] = 45;
        add_pos(pack_counts(c));
        run_setting(RAND_PER_SET);

        // zero thresholds: empty position calls as haploid T (zero denominators)
        set_thresholds(0, 0, 0, 0);
        run_setting(RAND_PER_SET);
        set_thresholds(65535, 65535, 65535, 65535);
        run_setting(RAND_PER_SET);
        set_thresholds(10, 200, 300, 128);
        run_setting(RAND_PER_SET);
        set_thresholds(1, 256, 256, 256);
        run_setting(RAND_PER_SET);
        set_thresholds($urandom_range(0, 300), $urandom_range(100, 256),
                       $urandom_range(256, 1024), $urandom_range(64, 256));
        run_setting(RAND_PER_SET);
        set_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_setting(RAND_PER_SET);
        set_thresholds($urandom_range(0, 300), $urandom_range(100, 256),
                       $urandom_range(256, 1024), $urandom_range(64, 256));
        run_setting(RAND_PER_SET);
        set_thresholds(RST_MIN_COVERAGE, RST_MIN_FRACTION,
                       RST_NEXT_MARGIN, RST_MAX_DISCREPANCY);
        run_setting(RAND_PER_SET);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d positions over %0d threshold settings, %0d mismatches",
                 n_rcvd, n_settings, err_cnt);
        $display("Calls seen: haploid %0d, diploid %0d, untrusted %0d",
                 n_hap, n_dip, n_untr);
        if (err_cnt == 0 && call_q.size() == 0 && n_rcvd == n_sent)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pcc_pkg.sv
sv/pileup_consensus_call.sv
dv/tb_pileup_consensus_call.sv
